// File: rtl/wnps_pkg.sv
`timescale 1ns / 1ps

package wnps_pkg;

    localparam int GRID_COLS_DEF  = 16;
    localparam int GRID_ROWS_DEF  = 16;
    localparam int NUM_POINTS_DEF = 16;

    // point storage
    localparam int POS_W   = 16;
    localparam int VEL_W   = 7;
    localparam int ENTRY_W = 2 * POS_W + 2 * VEL_W;

    // distance path: positions never exceed 14 bits, pixel centers 12 bits
    localparam int DX_W   = POS_W + 1;
    localparam int SQ_W   = 28;
    localparam int D2_W   = SQ_W + 1;
    localparam int RAD_W  = D2_W + 9;       // squared distance with 8 fraction bits, padded to even
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);

    localparam logic [7:0] SHADE_MAX = 8'd255;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_ADV  = 2'd1,
        KIND_PIX  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_PIX,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } point_t;

endpackage

// File: rtl/wnps_ram.sv
`timescale 1ns / 1ps

module wnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/worley_noise_pixel_shader_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  kind, point_index, load_pos_*, load_vel_*, pixel_*
// m_        out        m_valid / m_ready  shade, is_pixel
//
// points stream from the point ram one per cycle; pixel adds the
// bit-serial square root, both roots side by side
// aresetn clears all points to zero through per-entry valid bits, no sweep
// one item at a time; a result waiting on m_ready holds off the next item only
// once that item's own result is ready

module worley_noise_pixel_shader_unit
    import wnps_pkg::*;
#(
    parameter int GRID_COLS  = GRID_COLS_DEF,
    parameter int GRID_ROWS  = GRID_ROWS_DEF,
    parameter int NUM_POINTS = NUM_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_point_index,
    input  logic [11:0] s_load_pos_x,
    input  logic [11:0] s_load_pos_y,
    input  logic [5:0]  s_load_vel_x,
    input  logic [5:0]  s_load_vel_y,
    input  logic [3:0]  s_pixel_col,
    input  logic [3:0]  s_pixel_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_shade,
    output logic        m_is_pixel
);

    localparam int AW = $clog2(NUM_POINTS);
    localparam logic [POS_W-1:0]  MaxX     = POS_W'((GRID_COLS - 1) * 256);
    localparam logic [POS_W-1:0]  MaxY     = POS_W'((GRID_ROWS - 1) * 256);
    localparam logic [AW-1:0]     LastIdx  = AW'(NUM_POINTS - 1);
    localparam logic [STEP_W-1:0] LastStep = STEP_W'(ROOT_W - 1);

    state_t state_reg, state_next;

    logic                  accept;
    logic                  load_en;
    logic                  out_free;
    logic [AW-1:0]         cnt_reg;
    logic                  issue_reg;
    logic                  s1_vld_reg;
    logic                  s2_vld_reg;
    logic [AW-1:0]         wr_addr_reg;
    logic                  rd_valid_reg;
    logic [NUM_POINTS-1:0] valid_reg;

    logic [3:0]            px_reg, py_reg;
    logic [SQ_W-1:0]       sq_x_reg, sq_y_reg;
    logic [D2_W-1:0]       f1_reg, f2_reg;
    logic [RAD_W-1:0]      rad1_reg, rad2_reg;
    logic [REM_W-1:0]      rem1_reg, rem2_reg;
    logic [ROOT_W-1:0]     root1_reg, root2_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  res_pix_reg;

    logic                  m_valid_reg;
    logic [7:0]            m_shade_reg;
    logic                  m_is_pixel_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    point_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    point_t                pt_rd;
    point_t                pt_load;
    point_t                pt_adv;
    logic signed [DX_W-1:0]   dx, dy;
    logic signed [2*DX_W-1:0] prod_x, prod_y;
    logic [D2_W-1:0]       d2;
    logic [REM_W+ROOT_W-1:0] step1, step2;
    logic [ROOT_W-1:0]     diff;
    logic [ROOT_W-6:0]     diff_int;
    logic [7:0]            shade_val;

    function automatic logic [POS_W+VEL_W-1:0] move_axis(
        input logic [POS_W-1:0]        pos,
        input logic signed [VEL_W-1:0] vel,
        input logic [POS_W-1:0]        maxv
    );
        logic signed [POS_W+1:0] sum;
        logic signed [VEL_W-1:0] vneg;
        sum  = $signed({2'b00, pos}) + $signed({{(POS_W+2-VEL_W){vel[VEL_W-1]}}, vel});
        vneg = -vel;
        if (sum[POS_W+1]) begin
            return {{POS_W{1'b0}}, vneg};
        end else if (sum > $signed({2'b00, maxv})) begin
            return {maxv, vneg};
        end
        return {sum[POS_W-1:0], vel};
    endfunction

    // one restoring square-root step: remainder and root in, remainder and root out
    function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(
        input logic [REM_W-1:0]  rem,
        input logic [ROOT_W-1:0] root,
        input logic [1:0]        pair
    );
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {rem[REM_W-3:0], pair};
        trial  = {root, 2'b01};
        if (rem_sh >= trial) begin
            return {rem_sh - trial, root[ROOT_W-2:0], 1'b1};
        end
        return {rem_sh, root[ROOT_W-2:0], 1'b0};
    endfunction

    wnps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign load_en    = accept && (s_kind == KIND_LOAD) && (32'(s_point_index) < NUM_POINTS);
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_shade    = m_shade_reg;
    assign m_is_pixel = m_is_pixel_reg;

    always_comb begin
        // never-written entries read as the reset point
        pt_rd = rd_valid_reg ? point_t'(ram_rdata) : '0;

        pt_load.x  = {4'b0000, s_load_pos_x};
        pt_load.y  = {4'b0000, s_load_pos_y};
        pt_load.vx = {s_load_vel_x[5], s_load_vel_x};
        pt_load.vy = {s_load_vel_y[5], s_load_vel_y};

        {pt_adv.x, pt_adv.vx} = move_axis(pt_rd.x, pt_rd.vx, MaxX);
        {pt_adv.y, pt_adv.vy} = move_axis(pt_rd.y, pt_rd.vy, MaxY);

        ram_we    = load_en || ((state_reg == ST_ADV) && s1_vld_reg);
        ram_waddr = load_en ? AW'(s_point_index) : wr_addr_reg;
        ram_wdata = load_en ? pt_load : pt_adv;

        dx     = $signed({1'b0, pt_rd.x}) - $signed({5'b00000, px_reg, 8'h00});
        dy     = $signed({1'b0, pt_rd.y}) - $signed({5'b00000, py_reg, 8'h00});
        prod_x = dx * dx;
        prod_y = dy * dy;
        d2     = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

        step1 = sqrt_step(rem1_reg, root1_reg, rad1_reg[RAD_W-1 -: 2]);
        step2 = sqrt_step(rem2_reg, root2_reg, rad2_reg[RAD_W-1 -: 2]);

        diff      = (root2_reg >= root1_reg) ? (root2_reg - root1_reg) : '0;
        // drop 4 fraction bits, then halve
        diff_int  = diff[ROOT_W-1:5];
        shade_val = (|diff_int[ROOT_W-6:8]) ? SHADE_MAX : diff_int[7:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_ADV: state_next = ST_ADV;
                        KIND_PIX: state_next = ST_PIX;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADV: begin
                if (!issue_reg && !s1_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_PIX: begin
                if (!issue_reg && !s1_vld_reg && !s2_vld_reg) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (step_reg == LastStep) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            issue_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (accept && ((s_kind == KIND_ADV) || (s_kind == KIND_PIX))) begin
                cnt_reg   <= '0;
                issue_reg <= 1'b1;
            end else if (issue_reg) begin
                issue_reg <= (cnt_reg != LastIdx);
                if (cnt_reg != LastIdx) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            s1_vld_reg <= issue_reg;
            s2_vld_reg <= s1_vld_reg && (state_reg == ST_PIX);
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[cnt_reg];
        wr_addr_reg  <= cnt_reg;

        if (accept) begin
            px_reg      <= s_pixel_col;
            py_reg      <= s_pixel_row;
            res_pix_reg <= (s_kind == KIND_PIX);
            f1_reg      <= '1;
            f2_reg      <= '1;
        end

        if (s1_vld_reg) begin
            sq_x_reg <= prod_x[SQ_W-1:0];
            sq_y_reg <= prod_y[SQ_W-1:0];
        end

        // a tie with the nearest goes to second nearest
        if (s2_vld_reg) begin
            if (d2 < f1_reg) begin
                f2_reg <= f1_reg;
                f1_reg <= d2;
            end else if (d2 < f2_reg) begin
                f2_reg <= d2;
            end
        end

        if ((state_reg == ST_PIX) && (state_next == ST_ROOT)) begin
            rad1_reg  <= {1'b0, f1_reg, 8'h00};
            rad2_reg  <= {1'b0, f2_reg, 8'h00};
            rem1_reg  <= '0;
            rem2_reg  <= '0;
            root1_reg <= '0;
            root2_reg <= '0;
            step_reg  <= '0;
        end else if (state_reg == ST_ROOT) begin
            {rem1_reg, root1_reg} <= step1;
            {rem2_reg, root2_reg} <= step2;
            rad1_reg <= {rad1_reg[RAD_W-3:0], 2'b00};
            rad2_reg <= {rad2_reg[RAD_W-3:0], 2'b00};
            step_reg <= step_reg + 1'b1;
        end

        if ((state_reg == ST_DONE) && out_free) begin
            m_shade_reg    <= res_pix_reg ? shade_val : 8'h00;
            m_is_pixel_reg <= res_pix_reg;
        end
    end

endmodule

// File: rtl/wnps_checker.sv
`timescale 1ns / 1ps

module wnps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_shade,
    input logic        m_is_pixel
);

    // stalled word stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_shade) && $stable(m_is_pixel))
        else $error("result word changed while stalled");

    // non-pixel words carry zero shade
    a_zero_shade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_pixel |-> m_shade == 8'h00)
        else $error("non-pixel word with nonzero shade");

    // busy right after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind worley_noise_pixel_shader_unit wnps_checker u_wnps_checker (.*);
